@@ sv/lgtr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgtr_pkg
// Shared types, codes and helper functions of the glyph text renderer.
// ----------------------------------------------------------------------------
package lgtr_pkg;

  // Default geometry of the panel, of the band that a new line clears, and the queue depth.
  localparam int unsigned LGTR_SCREEN_WIDTH  = 240;
  localparam int unsigned LGTR_SCREEN_HEIGHT = 135;
  localparam int unsigned LGTR_CLEAR_ROWS    = 16;
  localparam int unsigned LGTR_QUEUE_DEPTH   = 2;

  // Input operations.
  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_CR    = 2'd1,
    OP_LF    = 2'd2
  } op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FG_COLOR    = 3'd0,
    REG_BG_COLOR    = 3'd1,
    REG_GLYPH_WIDTH = 3'd2,
    REG_GLYPH_HGT   = 3'd3,
    REG_COL_OFFSET  = 3'd4,
    REG_ROW_OFFSET  = 3'd5
  } cfg_reg_e;

  // Panel commands.
  localparam logic [7:0] CMD_CASET = 8'h2a;
  localparam logic [7:0] CMD_RASET = 8'h2b;
  localparam logic [7:0] CMD_RAMWR = 8'h2c;

  // Sequencer steps: band clear, glyph window, then eight pixels.
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_CLEAR_FIRST = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_CLEAR_RUN   = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_WIN_FIRST   = STEP_W'(12);
  localparam logic [STEP_W-1:0] STEP_WIN_LAST    = STEP_W'(22);
  localparam logic [STEP_W-1:0] STEP_PIX_FIRST   = STEP_W'(23);
  localparam logic [STEP_W-1:0] STEP_PIX_LAST    = STEP_W'(30);

  // Slots inside one window sequence.
  localparam logic [3:0] SLOT_CASET = 4'd0;
  localparam logic [3:0] SLOT_XS_HI = 4'd1;
  localparam logic [3:0] SLOT_XS_LO = 4'd2;
  localparam logic [3:0] SLOT_XE_HI = 4'd3;
  localparam logic [3:0] SLOT_XE_LO = 4'd4;
  localparam logic [3:0] SLOT_RASET = 4'd5;
  localparam logic [3:0] SLOT_YS_HI = 4'd6;
  localparam logic [3:0] SLOT_YS_LO = 4'd7;
  localparam logic [3:0] SLOT_YE_HI = 4'd8;
  localparam logic [3:0] SLOT_YE_LO = 4'd9;
  localparam logic [3:0] SLOT_RAMWR = 4'd10;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] glyph_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [11:0] repeat_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [2:0]  glyph_width_bytes;
    logic [5:0]  glyph_height;
    logic [8:0]  column_offset;
    logic [8:0]  row_offset;
  } cfg_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic       do_clear;
    logic [7:0] clear_y;
    logic       do_window;
    logic [7:0] win_x;
    logic [7:0] win_y;
    logic       do_pixels;
    logic [7:0] glyph_byte;
  } job_t;

  // Glyph width in bytes, clamped to one through four.
  function automatic logic [2:0] eff_width(input logic [2:0] w);
    logic [2:0] r;
    r = w;
    if (w == 3'd0) r = 3'd1;
    if (w > 3'd4) r = 3'd4;
    return r;
  endfunction

  // Glyph height in rows, clamped to one through 32.
  function automatic logic [5:0] eff_height(input logic [5:0] h);
    logic [5:0] r;
    r = h;
    if (h == 6'd0) r = 6'd1;
    if (h > 6'd32) r = 6'd32;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/lgtr_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgtr_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lgtr_fifo import lgtr_pkg::*; #(
  parameter int unsigned DEPTH = LGTR_QUEUE_DEPTH
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  wire  pop_i,
  output job_t head_job_o,
  output logic head_valid_o
);

  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  job_t               mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o       = (count_q == COUNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update, pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + COUNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(DEPTH))
    else $error("job queue fill count beyond depth");
`endif

endmodule
`default_nettype wire

@@ sv/lgtr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgtr_front
// Accepts input words, tracks the cursor and queues clear/window/pixel jobs.
// ----------------------------------------------------------------------------
module lgtr_front import lgtr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = LGTR_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = LGTR_SCREEN_HEIGHT
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  cfg_t     cfg_i,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  wire      queue_full_i,
  output logic     push_o,
  output job_t     push_job_o
);

  logic [7:0] cursor_x_q, cursor_x_d;
  logic [7:0] cursor_y_q, cursor_y_d;
  logic [6:0] byte_idx_q, byte_idx_d;

  logic [2:0] wb;
  logic [5:0] h;
  logic [8:0] wpx;
  logic [8:0] glyph_bytes;
  logic [7:0] next_y;
  logic       wrap;
  logic       glyph_end;
  logic [7:0] new_y;
  logic [7:0] new_x;
  logic       accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Effective glyph geometry.
  assign wb          = eff_width(cfg_i.glyph_width_bytes);
  assign h           = eff_height(cfg_i.glyph_height);
  assign wpx         = {3'd0, wb, 3'd0};
  assign glyph_bytes = 9'(wb) * 9'(h);

  // Next text line, back to the top when the next line would not fit.
  assign next_y = (9'(cursor_y_q) + {2'd0, h, 1'b0} - 9'd1 > 9'(SCREEN_HEIGHT - 1))
                  ? 8'd0 : cursor_y_q + 8'(h);

  // Line wrap at the first byte of a glyph that would not fit or would end on the last column.
  assign wrap      = (byte_idx_q == '0) && (9'(cursor_x_q) + wpx > 9'(SCREEN_WIDTH - 1));
  assign new_y     = wrap ? next_y : cursor_y_q;
  assign new_x     = wrap ? 8'd0 : cursor_x_q;
  assign glyph_end = (9'(byte_idx_q) + 9'd1 >= glyph_bytes);

  // Classification and cursor update.
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    byte_idx_d = byte_idx_q;
    push_o     = 1'b0;
    push_job_o = '0;
    push_job_o.glyph_byte = in_word_i.glyph_byte;
    case (in_word_i.operation)
      OP_GLYPH: begin
        push_o               = accept;
        push_job_o.do_clear  = wrap;
        push_job_o.clear_y   = new_y;
        push_job_o.do_window = (byte_idx_q == '0);
        push_job_o.win_x     = new_x;
        push_job_o.win_y     = new_y;
        push_job_o.do_pixels = 1'b1;
        cursor_y_d           = new_y;
        if (glyph_end) begin
          byte_idx_d = '0;
          cursor_x_d = new_x + wpx[7:0];
        end else begin
          byte_idx_d = byte_idx_q + 7'd1;
          cursor_x_d = new_x;
        end
      end
      OP_CR: begin
        push_o              = accept;
        push_job_o.do_clear = 1'b1;
        push_job_o.clear_y  = cursor_y_q;
        cursor_x_d          = 8'd0;
        byte_idx_d          = '0;
      end
      OP_LF: begin
        cursor_y_d = next_y;
        byte_idx_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      byte_idx_q <= '0;
    end else if (accept) begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      byte_idx_q <= byte_idx_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/lgtr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgtr_back
// Sequences queued jobs into command, parameter and pixel words.
// ----------------------------------------------------------------------------
module lgtr_back import lgtr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = LGTR_SCREEN_WIDTH,
  parameter int unsigned CLEAR_ROWS   = LGTR_CLEAR_ROWS
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  cfg_t      cfg_i,
  input  wire       job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned CLEAR_PIX = SCREEN_WIDTH * CLEAR_ROWS;
  localparam logic [11:0] CLEAR_CNT = (CLEAR_PIX > 4095) ? 12'd4095 : 12'(CLEAR_PIX);

  logic              active_q, active_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] cur_step, start_step, end_step, next_step;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q;
  out_word_t         res;
  logic              emit;
  logic              in_clear;
  logic [3:0]        slot;
  logic [2:0]        pix;
  logic [2:0]        wb;
  logic [5:0]        h;
  logic [8:0]        xs, xe, ys, ye;
  logic [15:0]       addr;

  assign wb = eff_width(cfg_i.glyph_width_bytes);
  assign h  = eff_height(cfg_i.glyph_height);

  // First and final step of the job at the head of the queue.
  assign start_step = job_i.do_clear ? STEP_CLEAR_FIRST :
                      job_i.do_window ? STEP_WIN_FIRST : STEP_PIX_FIRST;
  assign end_step   = job_i.do_pixels ? STEP_PIX_LAST :
                      job_i.do_window ? STEP_WIN_LAST : STEP_CLEAR_RUN;
  assign cur_step   = active_q ? step_q : start_step;

  always_comb begin
    if (cur_step == STEP_CLEAR_RUN) begin
      next_step = job_i.do_window ? STEP_WIN_FIRST : STEP_PIX_FIRST;
    end else if (cur_step == STEP_WIN_LAST) begin
      next_step = STEP_PIX_FIRST;
    end else begin
      next_step = cur_step + STEP_W'(1);
    end
  end

  // Window corners: the full-width band while clearing, the glyph cell after.
  assign in_clear = (cur_step <= STEP_CLEAR_RUN);
  assign slot     = in_clear ? cur_step[3:0] : 4'(cur_step - STEP_WIN_FIRST);
  assign pix      = 3'(cur_step - STEP_PIX_FIRST);

  always_comb begin
    if (in_clear) begin
      xs = 9'd0;
      xe = 9'(SCREEN_WIDTH - 1);
      ys = 9'(job_i.clear_y);
      ye = 9'(job_i.clear_y) + 9'(CLEAR_ROWS - 1);
    end else begin
      xs = 9'(job_i.win_x);
      xe = 9'(job_i.win_x) + {3'd0, wb, 3'd0} - 9'd1;
      ys = 9'(job_i.win_y);
      ye = 9'(job_i.win_y) + 9'(h) - 9'd1;
    end
  end

  // Address carried by the current parameter slot.
  always_comb begin
    case (slot)
      SLOT_XS_HI, SLOT_XS_LO: addr = 16'(cfg_i.column_offset) + 16'(xs);
      SLOT_XE_HI, SLOT_XE_LO: addr = 16'(cfg_i.column_offset) + 16'(xe);
      SLOT_YS_HI, SLOT_YS_LO: addr = 16'(cfg_i.row_offset) + 16'(ys);
      SLOT_YE_HI, SLOT_YE_LO: addr = 16'(cfg_i.row_offset) + 16'(ye);
      default:                addr = 16'd0;
    endcase
  end

  // Result word of the current step.
  always_comb begin
    res              = '0;
    res.repeat_count = 12'd1;
    res.last         = (cur_step == end_step);
    if (cur_step == STEP_CLEAR_RUN) begin
      res.kind         = KIND_PIXEL;
      res.value        = cfg_i.bg_color;
      res.repeat_count = CLEAR_CNT;
    end else if (cur_step >= STEP_PIX_FIRST) begin
      res.kind  = KIND_PIXEL;
      res.value = job_i.glyph_byte[~pix] ? cfg_i.fg_color : cfg_i.bg_color;
    end else begin
      case (slot)
        SLOT_CASET: begin
          res.kind  = KIND_CMD;
          res.value = {8'd0, CMD_CASET};
        end
        SLOT_RASET: begin
          res.kind  = KIND_CMD;
          res.value = {8'd0, CMD_RASET};
        end
        SLOT_XS_HI, SLOT_XE_HI, SLOT_YS_HI, SLOT_YE_HI: begin
          res.kind  = KIND_PARAM;
          res.value = {8'd0, addr[15:8]};
        end
        SLOT_XS_LO, SLOT_XE_LO, SLOT_YS_LO, SLOT_YE_LO: begin
          res.kind  = KIND_PARAM;
          res.value = {8'd0, addr[7:0]};
        end
        default: begin
          res.kind  = KIND_CMD;
          res.value = {8'd0, CMD_RAMWR};
        end
      endcase
    end
  end

  // One word per cycle while a job is queued and the output register is free or drains.
  assign emit      = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_pop_o = emit && res.last;

  always_comb begin
    active_d    = active_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (res.last) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        step_d   = next_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= STEP_CLEAR_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output data register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_active_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> job_valid_i)
    else $error("sequencer mid-job without a queued job");
  a_byte_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind != KIND_PIXEL) |-> out_q.repeat_count == 12'd1)
    else $error("command or parameter word with repeat count other than one");
`endif

endmodule
`default_nettype wire

@@ sv/lcd_glyph_text_renderer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_glyph_text_renderer
// Bitmap font text renderer producing RGB565 panel window and pixel words.
// ----------------------------------------------------------------------------
// An input word passes through the job queue and the output register before its
// first result word is valid. The back sequencer sends one result word per cycle
// while a job is queued and the output is not stalled; a glyph byte gives 8 pixel
// words, 19 at a glyph's first byte, 31 with a line wrap; a carriage return gives
// 12 words and a line feed none. Reset clears the cursor, the job queue and the
// output valid flag and loads the register defaults; no clearing pass is needed.
module lcd_glyph_text_renderer import lgtr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = LGTR_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = LGTR_SCREEN_HEIGHT,
  parameter int unsigned CLEAR_ROWS    = LGTR_CLEAR_ROWS,
  parameter int unsigned QUEUE_DEPTH   = LGTR_QUEUE_DEPTH
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire  [2:0] cfg_index_i,
  input  wire [15:0] cfg_data_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_word_t  out_word_o
);

  cfg_t cfg_q;
  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  job_t head_job;
  logic head_valid;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_color          <= 16'hffff;
      cfg_q.bg_color          <= 16'h0000;
      cfg_q.glyph_width_bytes <= 3'd1;
      cfg_q.glyph_height      <= 6'd16;
      cfg_q.column_offset     <= 9'd0;
      cfg_q.row_offset        <= 9'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FG_COLOR:    cfg_q.fg_color          <= cfg_data_i;
        REG_BG_COLOR:    cfg_q.bg_color          <= cfg_data_i;
        REG_GLYPH_WIDTH: cfg_q.glyph_width_bytes <= cfg_data_i[2:0];
        REG_GLYPH_HGT:   cfg_q.glyph_height      <= cfg_data_i[5:0];
        REG_COL_OFFSET:  cfg_q.column_offset     <= cfg_data_i[8:0];
        REG_ROW_OFFSET:  cfg_q.row_offset        <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  lgtr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  lgtr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_job_o   (head_job),
    .head_valid_o (head_valid)
  );

  lgtr_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .CLEAR_ROWS   (CLEAR_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/lcd_glyph_text_renderer_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_glyph_text_renderer_tb
// Self-checking bench for the glyph text renderer. A driver sends glyph
// bytes, carriage returns and line feeds in bursts, and writes registers
// while the block is idle. A monitor stalls the result channel, predicts
// every panel command, parameter and pixel word, and compares each field.
// ----------------------------------------------------------------------------
module lcd_glyph_text_renderer_tb;
  import lgtr_pkg::*;

  // Run limits, idle windows in clock cycles, the random word budget and the report limit.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned SETTLE_IDLE  = 10;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned RANDOM_WORDS = 190;
  localparam int unsigned REPORT_LIMIT = 40;

  // Codes that the block has no name for: an unused operation and two spare
  // register indexes. All three must be ignored.
  localparam logic [1:0] OP_UNKNOWN  = 2'd3;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // What the driver does with one queued entry.
  typedef enum logic [1:0] {
    ACT_WORD = 2'd0,
    ACT_REG  = 2'd1,
    ACT_HOLD = 2'd2
  } act_e;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {
    SINK_OPEN     = 2'd0,
    SINK_COIN     = 2'd1,
    SINK_SPARSE   = 2'd2,
    SINK_PERIODIC = 2'd3
  } sink_mode_e;

  typedef struct packed {
    act_e       act;
    logic [2:0] reg_idx;
    logic [15:0] reg_data;
    in_word_t   word;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;

  lcd_glyph_text_renderer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Pending stimulus and the sizes that the plan expects after each write.
  stim_t       stim_q[$];
  int unsigned plan_wb = 1;
  int unsigned plan_h = 16;
  int unsigned planned_words = 0;

  // Predicted panel words and the predictor's copy of state and registers.
  out_word_t   panel_words_due[$];
  logic [15:0] fg_q, bg_q;
  logic [2:0]  width_q;
  logic [5:0]  height_q;
  logic [8:0]  col_off_q, row_off_q;
  int unsigned cur_x, cur_y, byte_idx;

  // Handshake summary shared from the monitor to the driver and the end check.
  int unsigned backlog = 0;
  int unsigned quiet = 0;

  // Statistics.
  int unsigned errors = 0;
  int unsigned words_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned glyph_bytes_seen = 0;
  int unsigned returns_seen = 0;
  int unsigned feeds_seen = 0;
  int unsigned line_wraps = 0;
  int unsigned bands_cleared = 0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------------------
  // Stimulus planning.
  // ---------------------------------------------------------------------------
  task automatic add_word(input logic [1:0] op, input logic [7:0] data);
    stim_t e;
    e = '0;
    e.act = ACT_WORD;
    e.word.operation = op;
    e.word.glyph_byte = data;
    stim_q.push_back(e);
    if (op != OP_UNKNOWN) planned_words++;
  endtask

  task automatic add_reg(input logic [2:0] idx, input logic [15:0] data);
    stim_t e;
    e = '0;
    e.act = ACT_REG;
    e.reg_idx = idx;
    e.reg_data = data;
    stim_q.push_back(e);
    if (idx == REG_GLYPH_WIDTH) begin
      plan_wb = (data[2:0] == 3'd0) ? 1 : (data[2:0] > 3'd4) ? 4 : data[2:0];
    end
    if (idx == REG_GLYPH_HGT) begin
      plan_h = (data[5:0] == 6'd0) ? 1 : (data[5:0] > 6'd32) ? 32 : data[5:0];
    end
  endtask

  task automatic add_hold();
    stim_t e;
    e = '0;
    e.act = ACT_HOLD;
    stim_q.push_back(e);
  endtask

  task automatic add_glyph(input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++) add_word(OP_GLYPH, 8'($urandom));
  endtask

  function automatic logic [15:0] pick_color();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_offset();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'd319 : 16'd0;
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction of the panel words caused by one input word.
  // ---------------------------------------------------------------------------
  task automatic push_word(input kind_e kind, input int unsigned value,
                           input int unsigned rep);
    out_word_t w;
    w.kind = kind;
    w.value = 16'(value);
    w.repeat_count = 12'(rep);
    w.last = 1'b0;
    panel_words_due.push_back(w);
  endtask

  // An address goes out as two parameter bytes, high byte first.
  task automatic push_addr(input int unsigned addr);
    int unsigned a;
    a = addr & 32'hFFFF;
    push_word(KIND_PARAM, a >> 8, 1);
    push_word(KIND_PARAM, a & 32'hFF, 1);
  endtask

  task automatic push_window(input int unsigned xs, input int unsigned ys,
                             input int unsigned xe, input int unsigned ye);
    push_word(KIND_CMD, CMD_CASET, 1);
    push_addr(col_off_q + xs);
    push_addr(col_off_q + xe);
    push_word(KIND_CMD, CMD_RASET, 1);
    push_addr(row_off_q + ys);
    push_addr(row_off_q + ye);
    push_word(KIND_CMD, CMD_RAMWR, 1);
  endtask

  // A band clear is a full-width window and one background run.
  task automatic push_band_clear(input int unsigned y);
    int unsigned run;
    run = LGTR_SCREEN_WIDTH * LGTR_CLEAR_ROWS;
    if (run > 4095) run = 4095;
    push_window(0, y, LGTR_SCREEN_WIDTH - 1, y + LGTR_CLEAR_ROWS - 1);
    push_word(KIND_PIXEL, bg_q, run);
    bands_cleared++;
  endtask

  // Next text row, or the top when another line would not fit.
  function automatic int unsigned next_text_row(input int unsigned y,
                                                input int unsigned h);
    if (y + 2 * h - 1 > LGTR_SCREEN_HEIGHT - 1) return 0;
    return (y + h) & 32'hFF;
  endfunction

  task automatic render_panel_words(input in_word_t w);
    int unsigned wb, wpx, h, start;
    out_word_t   tail;
    wb = (width_q == 3'd0) ? 1 : (width_q > 3'd4) ? 4 : width_q;
    h = (height_q == 6'd0) ? 1 : (height_q > 6'd32) ? 32 : height_q;
    wpx = wb * 8;
    start = panel_words_due.size();
    case (w.operation)
      OP_CR: begin
        returns_seen++;
        cur_x = 0;
        byte_idx = 0;
        push_band_clear(cur_y);
      end
      OP_LF: begin
        feeds_seen++;
        cur_y = next_text_row(cur_y, h);
        byte_idx = 0;
      end
      OP_GLYPH: begin
        glyph_bytes_seen++;
        // The first byte of a glyph wraps the line if needed and opens a window.
        if (byte_idx == 0) begin
          if (cur_x + wpx > LGTR_SCREEN_WIDTH - 1) begin
            line_wraps++;
            cur_x = 0;
            cur_y = next_text_row(cur_y, h);
            push_band_clear(cur_y);
          end
          push_window(cur_x, cur_y, cur_x + wpx - 1, cur_y + h - 1);
        end
        for (int k = 7; k >= 0; k--) begin
          push_word(KIND_PIXEL, w.glyph_byte[k] ? fg_q : bg_q, 1);
        end
        if (byte_idx + 1 >= wb * h) begin
          byte_idx = 0;
          cur_x = (cur_x + wpx) & 32'hFF;
        end else begin
          byte_idx = (byte_idx + 1) & 32'h7F;
        end
      end
      default: begin
      end
    endcase
    // Flag the final word of this input word.
    if (panel_words_due.size() > start) begin
      tail = panel_words_due.pop_back();
      tail.last = 1'b1;
      panel_words_due.push_back(tail);
    end
  endtask

  task automatic apply_reg_write(input logic [2:0] idx, input logic [15:0] data);
    reg_writes++;
    case (idx)
      REG_FG_COLOR:    fg_q = data;
      REG_BG_COLOR:    bg_q = data;
      REG_GLYPH_WIDTH: width_q = data[2:0];
      REG_GLYPH_HGT:   height_q = data[5:0];
      REG_COL_OFFSET:  col_off_q = data[8:0];
      REG_ROW_OFFSET:  row_off_q = data[8:0];
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: input words in bursts, register writes only once the block is idle.
  // ---------------------------------------------------------------------------
  stim_t       head;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned since_in = 0;
  logic        nxt_in_valid, nxt_cfg_valid;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
      burst_left = 0;
      gap_left = 0;
      since_in = 0;
    end else begin
      if (in_valid && in_ready) since_in = 0;
      else if (since_in < 1000) since_in++;
      if (!(in_valid && !in_ready) && !(cfg_valid && !cfg_ready)) begin
        nxt_in_valid = 1'b0;
        nxt_cfg_valid = 1'b0;
        if (stim_q.size() != 0) begin
          head = stim_q[0];
          if (head.act == ACT_WORD) begin
            if (burst_left == 0 && gap_left == 0) begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (burst_left != 0) begin
              nxt_in_valid = 1'b1;
              in_word <= head.word;
              void'(stim_q.pop_front());
              burst_left--;
            end else begin
              gap_left--;
            end
          end else if (backlog == 0 && quiet >= SETTLE_IDLE &&
                       since_in >= SETTLE_IDLE) begin
            // Register writes and holds go ahead only after the block drained.
            if (head.act == ACT_REG) begin
              nxt_cfg_valid = 1'b1;
              cfg_index <= head.reg_idx;
              cfg_data <= head.reg_data;
            end
            void'(stim_q.pop_front());
          end
        end
        in_valid <= nxt_in_valid;
        cfg_valid <= nxt_cfg_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted word and checks every result word.
  // ---------------------------------------------------------------------------
  out_word_t   due_word;
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned sink_tick = 0;
  logic        in_fire, nxt_ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      backlog <= 0;
      quiet <= 0;
      fg_q = 16'hFFFF;
      bg_q = 16'h0000;
      width_q = 3'd1;
      height_q = 6'd16;
      col_off_q = '0;
      row_off_q = '0;
      cur_x = 0;
      cur_y = 0;
      byte_idx = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      in_fire = in_valid && in_ready;
      if (in_fire) render_panel_words(in_word);

      if (out_valid && out_ready) begin
        if (panel_words_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: unexpected result word: kind %0d value %h repeat %0d last %b",
                     $time, out_word.kind, out_word.value, out_word.repeat_count,
                     out_word.last);
          end
        end else begin
          due_word = panel_words_due.pop_front();
          if (due_word.kind !== out_word.kind || due_word.value !== out_word.value ||
              due_word.repeat_count !== out_word.repeat_count ||
              due_word.last !== out_word.last) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: result word %0d: expected kind %0d value %h repeat %0d last %b",
                       $time, words_checked, due_word.kind, due_word.value,
                       due_word.repeat_count, due_word.last);
              $display("%0t: result word %0d:   actual kind %0d value %h repeat %0d last %b",
                       $time, words_checked, out_word.kind, out_word.value,
                       out_word.repeat_count, out_word.last);
            end
          end
          words_checked++;
        end
      end

      // The receiver switches between open, random, sparse and periodic stalls.
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        sink_left = $urandom_range(20, 120);
      end else begin
        sink_left--;
      end
      sink_tick++;
      case (sink_mode)
        SINK_OPEN:   nxt_ready = 1'b1;
        SINK_COIN:   nxt_ready = 1'($urandom_range(0, 1));
        SINK_SPARSE: nxt_ready = ($urandom_range(0, 5) == 0);
        default:     nxt_ready = (sink_tick % 4) < 2;
      endcase
      out_ready <= nxt_ready;

      backlog <= panel_words_due.size();
      if (panel_words_due.size() == 0 && !in_fire && !out_valid) begin
        quiet <= (quiet < 1000) ? quiet + 1 : quiet;
      end else begin
        quiet <= 0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit with %0d words still due",
               $time, panel_words_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick, glyph_len, n_ops;

    // Default registers: a glyph start, a partial glyph dropped by a carriage
    // return, another dropped by a line feed, and an ignored operation.
    add_word(OP_GLYPH, 8'hFF);
    add_word(OP_GLYPH, 8'h00);
    add_word(OP_CR, 8'h00);
    add_word(OP_GLYPH, 8'h5A);
    add_word(OP_LF, 8'hFF);
    add_word(OP_UNKNOWN, 8'hA5);
    add_hold();

    // Extreme colors and offsets, the widest glyph one row high, junk in the
    // unused register bits.
    add_reg(REG_FG_COLOR, 16'h0000);
    add_reg(REG_BG_COLOR, 16'hFFFF);
    add_reg(REG_GLYPH_WIDTH, 16'hFFF8 | 16'd4);
    add_reg(REG_GLYPH_HGT, 16'hFFC0 | 16'd1);
    add_reg(REG_COL_OFFSET, 16'hFE00 | 16'd319);
    add_reg(REG_ROW_OFFSET, 16'd319);
    add_word(OP_GLYPH, 8'h80);
    add_word(OP_GLYPH, 8'h01);

    // Shrinking the glyph part way through ends it at the next byte.
    add_reg(REG_GLYPH_WIDTH, 16'd0);
    add_word(OP_GLYPH, 8'hC3);
    add_word(OP_GLYPH, 8'h3C);

    // Out-of-range sizes clamp; tall lines send the line feed back to the top.
    add_reg(REG_GLYPH_WIDTH, 16'd7);
    add_reg(REG_GLYPH_HGT, 16'd0);
    add_word(OP_GLYPH, 8'hE7);
    add_reg(REG_GLYPH_HGT, 16'd63);
    add_word(OP_LF, 8'h00);
    add_word(OP_LF, 8'h81);
    add_word(OP_LF, 8'h7E);
    add_reg(REG_GLYPH_WIDTH, 16'd5);
    add_reg(REG_GLYPH_HGT, 16'd33);
    add_word(OP_GLYPH, 8'h7E);
    add_reg(REG_SPARE_6, 16'($urandom));
    add_reg(REG_SPARE_7, 16'($urandom));
    add_word(OP_CR, 8'hFF);

    // Random phases: a new register setting, then mostly whole glyphs with
    // random bitmaps, mixed with returns, feeds, cut glyphs and noise.
    while (planned_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) != 0) add_reg(REG_FG_COLOR, pick_color());
      if ($urandom_range(0, 2) != 0) add_reg(REG_BG_COLOR, pick_color());
      if ($urandom_range(0, 2) != 0) add_reg(REG_GLYPH_WIDTH, 16'($urandom));
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 7) == 0) add_reg(REG_GLYPH_HGT, 16'($urandom));
        else add_reg(REG_GLYPH_HGT, (16'($urandom) & 16'hFFC0) | 16'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 2) != 0) add_reg(REG_COL_OFFSET, pick_offset());
      if ($urandom_range(0, 2) != 0) add_reg(REG_ROW_OFFSET, pick_offset());
      glyph_len = plan_wb * plan_h;
      n_ops = $urandom_range(6, 16);
      for (int unsigned j = 0; j < n_ops; j++) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          add_glyph((glyph_len <= 16) ? glyph_len : $urandom_range(1, 6));
        end else if (pick < 15) begin
          add_word(OP_CR, 8'($urandom));
        end else if (pick < 17) begin
          add_word(OP_LF, 8'($urandom));
        end else if (pick == 17) begin
          add_glyph($urandom_range(1, (glyph_len < 8) ? glyph_len : 8));
          add_word($urandom_range(0, 1) ? OP_CR : OP_LF, 8'($urandom));
        end else if (pick == 18) begin
          add_word(OP_UNKNOWN, 8'($urandom));
        end else begin
          add_hold();
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the plan to run out and every predicted word to arrive.
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid || cfg_valid || backlog != 0 ||
           quiet < SETTLE_IDLE);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (panel_words_due.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted words never arrived, next: kind %0d value %h",
               $time, panel_words_due.size(), panel_words_due[0].kind,
               panel_words_due[0].value);
    end

    $display("Covered %0d glyph bytes, %0d returns, %0d line feeds, %0d register writes.",
             glyph_bytes_seen, returns_seen, feeds_seen, reg_writes);
    $display("Checked %0d result words with %0d line wraps and %0d band clears; %0d errors.",
             words_checked, line_wraps, bands_cleared, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
